>>> design/abat_pkg.sv
// ----------------------------------------------------------------------------
// abat_pkg
// Shared types and constants for the two-axis alpha-beta aim tracker.
// ----------------------------------------------------------------------------
package abat_pkg;

	// Rate estimate width default
	localparam int RATE_BITS_DEF = 24;

	// Output rate width and shared multiplier operand B width
	localparam int OUT_RATE_W = 24;
	localparam int MUL_B_W    = 28;

	// Angle constants in 1/128 degree
	localparam logic signed [17:0] HALF_TURN = 18'sd23040;
	localparam logic signed [17:0] FULL_TURN = 18'sd46080;

	// Reciprocal of 45 scaled by 2^32, used for the wide angle reduction
	localparam logic [26:0] RECIP45 = 27'd95443718;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_HI    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_HI   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_WRAPS = 3'd7;

	// Register reset values
	localparam logic [15:0]        ALPHA_RST   = 16'd32768;
	localparam logic [23:0]        BETA_RST    = 24'd5120;
	localparam logic [15:0]        DT_RST      = 16'd655;
	localparam logic signed [15:0] PAN_LO_RST  = -16'sd23040;
	localparam logic signed [15:0] PAN_HI_RST  = 16'sd23040;
	localparam logic signed [15:0] TILT_LO_RST = -16'sd11520;
	localparam logic signed [15:0] TILT_HI_RST = 16'sd11520;

	// Observation request
	typedef struct packed {
		logic               obs_valid;
		logic               angles_ok;
		logic [15:0]        confidence_in;
		logic signed [15:0] bearing_in;
		logic signed [15:0] elevation_in;
		logic signed [15:0] pan_now;
		logic signed [15:0] tilt_now;
	} meas_t;

	// Aim result
	typedef struct packed {
		logic signed [15:0]           pan_target;
		logic signed [15:0]           tilt_target;
		logic signed [OUT_RATE_W-1:0] pan_rate;
		logic signed [OUT_RATE_W-1:0] tilt_rate;
		logic                         track_valid;
		logic [15:0]                  confidence_out;
	} aim_t;

endpackage

>>> design/abat_mul.sv
// ----------------------------------------------------------------------------
// abat_mul
// Shared signed multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module abat_mul #(
	parameter int A_W = 24,
	parameter int B_W = 28
) (
	input  logic                     clk,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] prod
);

	// Register the product every cycle
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

>>> design/two_axis_alpha_beta_aim_tracker.sv
// ----------------------------------------------------------------------------
// two_axis_alpha_beta_aim_tracker
// Alpha-beta tracker on bearing and elevation with wrap-aware residuals,
// driving pan and tilt targets through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  meas     | in        | meas_valid / meas_stall   | meas_t observation
//  aim      | out       | aim_valid / aim_stall     | aim_t targets and rates
//  cfg      | in        | cfg_we (no wait)          | cfg_index, cfg_data
//
//  A tracked request runs through an accept step, 8 sequencer steps per axis,
//  each axis using the shared multiplier four times, and an output step. A
//  seeding or unusable request goes from the accept step straight to output.
//  The next request is taken once the result is in the output register.
//  Reset clears the track state and loads the register defaults.
//  A stalled result holds in the output register; the sequencer waits in its
//  output step until the register is free.
// ----------------------------------------------------------------------------
module two_axis_alpha_beta_aim_tracker
	import abat_pkg::*;
#(
	parameter int RATE_BITS = RATE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  meas_valid,
	output logic                  meas_stall,
	input  meas_t                 meas,
	output logic                  aim_valid,
	input  logic                  aim_stall,
	output aim_t                  aim,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int P_W   = RATE_BITS + MUL_B_W;
	localparam int X_W   = RATE_BITS + 2;
	localparam int SUM_W = RATE_BITS + 21;
	localparam int SAT_W = (RATE_BITS > OUT_RATE_W) ? RATE_BITS : OUT_RATE_W;

	localparam logic signed [SUM_W-1:0] RATE_MAX =
		{{(SUM_W-RATE_BITS+1){1'b0}}, {(RATE_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] RATE_MIN =
		{{(SUM_W-RATE_BITS+1){1'b1}}, {(RATE_BITS-1){1'b0}}};
	localparam logic signed [SAT_W-1:0] OUT_MAX =
		{{(SAT_W-OUT_RATE_W+1){1'b0}}, {(OUT_RATE_W-1){1'b1}}};
	localparam logic signed [SAT_W-1:0] OUT_MIN =
		{{(SAT_W-OUT_RATE_W+1){1'b1}}, {(OUT_RATE_W-1){1'b0}}};

	// Sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MUL_DT = 4'd1;
	localparam logic [3:0] ST_PRED_X = 4'd2;
	localparam logic [3:0] ST_MUL_Q  = 4'd3;
	localparam logic [3:0] ST_PRED_W = 4'd4;
	localparam logic [3:0] ST_RES    = 4'd5;
	localparam logic [3:0] ST_MUL_A  = 4'd6;
	localparam logic [3:0] ST_EST    = 4'd7;
	localparam logic [3:0] ST_RATE   = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	// Fold a value within one turn of the range back into [-180, 180)
	function automatic logic signed [15:0] wrap_small(input logic signed [17:0] v);
		logic signed [17:0] w;
		if (v >= HALF_TURN) begin
			w = v - FULL_TURN;
		end else if (v < -HALF_TURN) begin
			w = v + FULL_TURN;
		end else begin
			w = v;
		end
		return w[15:0];
	endfunction

	// Configuration registers
	logic [15:0]        alpha_q;
	logic [23:0]        beta_q;
	logic [15:0]        dt_q;
	logic signed [15:0] pan_lo_q;
	logic signed [15:0] pan_hi_q;
	logic signed [15:0] tilt_lo_q;
	logic signed [15:0] tilt_hi_q;
	logic               pan_wraps_q;

	// Sequencer and track state
	logic [3:0]                  state_q;
	logic                        ax_q;
	logic                        ok_q;
	logic                        have_track_q;
	meas_t                       item_q;
	logic signed [15:0]          bear_est_q;
	logic signed [15:0]          elev_est_q;
	logic signed [RATE_BITS-1:0] bear_rate_q;
	logic signed [RATE_BITS-1:0] elev_rate_q;
	logic signed [X_W-1:0]       x_q;
	logic signed [15:0]          pred_q;
	logic signed [15:0]          res_q;

	// Output register
	aim_t aim_q;
	logic aim_valid_q;

	// Datapath signals
	logic signed [RATE_BITS-1:0] mul_a;
	logic signed [MUL_B_W-1:0]   mul_b;
	logic signed [P_W-1:0]       prod;
	logic signed [P_W-1:0]       rnd16;
	logic signed [P_W-1:0]       rnd8;
	logic signed [RATE_BITS-1:0] dt_step;
	logic signed [15:0]          est_cur;
	logic signed [RATE_BITS-1:0] rate_cur;
	logic signed [15:0]          meas_cur;
	logic signed [X_W-1:0]       x_next;
	logic signed [RATE_BITS-1:0] t_ext;
	logic signed [RATE_BITS-1:0] res_ext;
	logic [13:0]                 m45;
	logic [17:0]                 r18;
	logic [17:0]                 r1;
	logic [17:0]                 r2;
	logic signed [15:0]          pred_next;
	logic signed [15:0]          res_next;
	logic signed [16:0]          alpha_term;
	logic signed [15:0]          est_next;
	logic signed [SUM_W-1:0]     rate_sum;
	logic signed [RATE_BITS-1:0] rate_next;
	logic                        ok_in;
	logic                        accept;
	logic                        aim_free;
	logic signed [17:0]          pan_sum;
	logic signed [17:0]          tilt_sum;
	logic signed [17:0]          pan_clip;
	logic signed [17:0]          tilt_clip;
	logic signed [15:0]          pan_t;
	logic signed [15:0]          tilt_t;
	logic signed [SAT_W-1:0]     bear_rate_w;
	logic signed [SAT_W-1:0]     elev_rate_w;
	logic signed [SAT_W-1:0]     pan_rate_s;
	logic signed [SAT_W-1:0]     tilt_rate_s;

	// Handshake
	assign meas_stall = (state_q != ST_IDLE);
	assign accept     = meas_valid && !meas_stall;
	assign ok_in      = meas.obs_valid && meas.angles_ok && (meas.confidence_in != 16'd0);
	assign aim_free   = !aim_valid_q || !aim_stall;
	assign aim_valid  = aim_valid_q;
	assign aim        = aim_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RST;
			beta_q      <= BETA_RST;
			dt_q        <= DT_RST;
			pan_lo_q    <= PAN_LO_RST;
			pan_hi_q    <= PAN_HI_RST;
			tilt_lo_q   <= TILT_LO_RST;
			tilt_hi_q   <= TILT_HI_RST;
			pan_wraps_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA:     alpha_q     <= cfg_data[15:0];
				REG_BETA:      beta_q      <= cfg_data[23:0];
				REG_DT:        dt_q        <= cfg_data[15:0];
				REG_PAN_LO:    pan_lo_q    <= cfg_data[15:0];
				REG_PAN_HI:    pan_hi_q    <= cfg_data[15:0];
				REG_TILT_LO:   tilt_lo_q   <= cfg_data[15:0];
				REG_TILT_HI:   tilt_hi_q   <= cfg_data[15:0];
				REG_PAN_WRAPS: pan_wraps_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Select the axis under work
	assign est_cur  = ax_q ? elev_est_q : bear_est_q;
	assign rate_cur = ax_q ? elev_rate_q : bear_rate_q;
	assign meas_cur = ax_q ? item_q.elevation_in : item_q.bearing_in;

	// Shared multiplier operands
	assign t_ext   = RATE_BITS'(x_q >>> 10);
	assign res_ext = RATE_BITS'(res_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_DT: begin
				mul_a = rate_cur;
				mul_b = MUL_B_W'(dt_q);
			end
			ST_MUL_Q: begin
				mul_a = t_ext;
				mul_b = MUL_B_W'(RECIP45);
			end
			ST_MUL_A: begin
				mul_a = res_ext;
				mul_b = MUL_B_W'(alpha_q);
			end
			ST_EST: begin
				mul_a = res_ext;
				mul_b = MUL_B_W'(beta_q);
			end
			default: ;
		endcase
	end

	abat_mul #(
		.A_W (RATE_BITS),
		.B_W (MUL_B_W)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Round the product to nearest, ties up
	assign rnd16 = prod + P_W'(32768);
	assign rnd8  = prod + P_W'(128);

	// Unwrapped prediction
	assign dt_step = rnd16[RATE_BITS+15:16];
	assign x_next  = X_W'(est_cur) + X_W'(dt_step);

	// Reduce the prediction by full turns: quotient from the reciprocal product,
	// remainder from its low bits, then at most one turn off each way
	assign m45       = {6'd0, prod[39:32]} * 14'd45;
	assign r18       = x_q[17:0] - {m45[7:0], 10'd0};
	assign r1        = (r18 >= 18'(FULL_TURN)) ? (r18 - 18'(FULL_TURN)) : r18;
	assign r2        = r1 - 18'(FULL_TURN);
	assign pred_next = (r1 >= 18'(HALF_TURN)) ? r2[15:0] : r1[15:0];

	// Residual, position and rate corrections
	assign res_next   = wrap_small(18'(meas_cur) - 18'(pred_q));
	assign alpha_term = rnd16[32:16];
	assign est_next   = wrap_small(18'(pred_q) + 18'(alpha_term));
	assign rate_sum   = SUM_W'(rate_cur) + SUM_W'(signed'(rnd8[P_W-1:8]));

	always_comb begin
		if (rate_sum > RATE_MAX) begin
			rate_next = RATE_MAX[RATE_BITS-1:0];
		end else if (rate_sum < RATE_MIN) begin
			rate_next = RATE_MIN[RATE_BITS-1:0];
		end else begin
			rate_next = rate_sum[RATE_BITS-1:0];
		end
	end

	// Step the sequencer and update the track
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ax_q         <= 1'b0;
			ok_q         <= 1'b0;
			have_track_q <= 1'b0;
			bear_est_q   <= '0;
			elev_est_q   <= '0;
			bear_rate_q  <= '0;
			elev_rate_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ok_q <= ok_in;
						ax_q <= 1'b0;
						if (ok_in && have_track_q) begin
							state_q <= ST_MUL_DT;
						end else begin
							if (ok_in) begin
								bear_est_q   <= wrap_small(18'(meas.bearing_in));
								elev_est_q   <= wrap_small(18'(meas.elevation_in));
								bear_rate_q  <= '0;
								elev_rate_q  <= '0;
								have_track_q <= 1'b1;
							end
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL_DT: state_q <= ST_PRED_X;
				ST_PRED_X: state_q <= ST_MUL_Q;
				ST_MUL_Q:  state_q <= ST_PRED_W;
				ST_PRED_W: state_q <= ST_RES;
				ST_RES:    state_q <= ST_MUL_A;
				ST_MUL_A:  state_q <= ST_EST;
				ST_EST: begin
					if (ax_q) begin
						elev_est_q <= est_next;
					end else begin
						bear_est_q <= est_next;
					end
					state_q <= ST_RATE;
				end
				ST_RATE: begin
					if (ax_q) begin
						elev_rate_q <= rate_next;
						state_q     <= ST_OUT;
					end else begin
						bear_rate_q <= rate_next;
						ax_q        <= 1'b1;
						state_q     <= ST_MUL_DT;
					end
				end
				ST_OUT: begin
					if (aim_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request and the per-step working values
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= meas;
		end
		if (state_q == ST_PRED_X) begin
			x_q <= x_next;
		end
		if (state_q == ST_PRED_W) begin
			pred_q <= pred_next;
		end
		if (state_q == ST_RES) begin
			res_q <= res_next;
		end
	end

	// Form targets: wrap or clamp pan, clamp tilt
	assign pan_sum  = 18'(item_q.pan_now) + 18'(bear_est_q);
	assign tilt_sum = 18'(item_q.tilt_now) + 18'(elev_est_q);

	always_comb begin
		pan_clip = (pan_sum > 18'(pan_hi_q)) ? 18'(pan_hi_q) : pan_sum;
		if (pan_clip < 18'(pan_lo_q)) begin
			pan_clip = 18'(pan_lo_q);
		end
		tilt_clip = (tilt_sum > 18'(tilt_hi_q)) ? 18'(tilt_hi_q) : tilt_sum;
		if (tilt_clip < 18'(tilt_lo_q)) begin
			tilt_clip = 18'(tilt_lo_q);
		end
	end

	assign pan_t  = pan_wraps_q ? wrap_small(pan_sum) : pan_clip[15:0];
	assign tilt_t = tilt_clip[15:0];

	// Saturate rates to the output width
	assign bear_rate_w = SAT_W'(bear_rate_q);
	assign elev_rate_w = SAT_W'(elev_rate_q);

	always_comb begin
		pan_rate_s = bear_rate_w;
		if (bear_rate_w > OUT_MAX) begin
			pan_rate_s = OUT_MAX;
		end else if (bear_rate_w < OUT_MIN) begin
			pan_rate_s = OUT_MIN;
		end
		tilt_rate_s = elev_rate_w;
		if (elev_rate_w > OUT_MAX) begin
			tilt_rate_s = OUT_MAX;
		end else if (elev_rate_w < OUT_MIN) begin
			tilt_rate_s = OUT_MIN;
		end
	end

	// Drop the result into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && aim_free) begin
			aim_valid_q <= 1'b1;
		end else if (!aim_stall) begin
			aim_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && aim_free) begin
			aim_q.confidence_out <= item_q.confidence_in;
			aim_q.track_valid    <= ok_q;
			if (ok_q) begin
				aim_q.pan_target  <= pan_t;
				aim_q.tilt_target <= tilt_t;
				aim_q.pan_rate    <= pan_rate_s[OUT_RATE_W-1:0];
				aim_q.tilt_rate   <= tilt_rate_s[OUT_RATE_W-1:0];
			end else begin
				aim_q.pan_target  <= item_q.pan_now;
				aim_q.tilt_target <= item_q.tilt_now;
				aim_q.pan_rate    <= '0;
				aim_q.tilt_rate   <= '0;
			end
		end
	end

endmodule

>>> design/abat_checker.sv
// ----------------------------------------------------------------------------
// abat_checker
// Port-level checks on the aim tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module abat_checker
	import abat_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  meas_valid,
	input logic  meas_stall,
	input logic  aim_valid,
	input logic  aim_stall,
	input aim_t  aim
);

	// A stalled result holds
	a_aim_hold: assert property (@(posedge clk) disable iff (!arst_n)
		aim_valid && aim_stall |=> aim_valid && $stable(aim))
		else $error("stalled aim result changed");

	// Block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && !meas_stall |=> meas_stall)
		else $error("request taken while previous one still in work");

	// No track means zero rates
	a_rates_zero: assert property (@(posedge clk) disable iff (!arst_n)
		aim_valid && !aim.track_valid |-> aim.pan_rate == '0 && aim.tilt_rate == '0)
		else $error("nonzero rate on an untracked result");

	// A tracked result carries a nonzero confidence
	a_conf_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		aim_valid && aim.track_valid |-> aim.confidence_out != 16'd0)
		else $error("tracked result with zero confidence");

endmodule

bind two_axis_alpha_beta_aim_tracker abat_checker u_abat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.meas_valid (meas_valid),
	.meas_stall (meas_stall),
	.aim_valid  (aim_valid),
	.aim_stall  (aim_stall),
	.aim        (aim)
);
